@@ design/lmsrs_pkg.sv @@
package lmsrs_pkg;

  // Fixed geometry of the glyph and the scan
  localparam int unsigned ROWS        = 8;
  localparam int unsigned GLYPH_WIDTH = 8;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned POS_W       = 3;
  localparam int unsigned REP_W       = 4;

  // Refresh repeat count limits
  localparam logic [REP_W-1:0] REPEAT_MAX   = 4'd8;
  localparam logic [REP_W-1:0] REPEAT_RESET = 4'd5;

  // Last scan position of a frame
  localparam logic [POS_W-1:0] POS_LAST = 3'd7;

  // Start request from the input side to the scan sequencer
  typedef struct packed {
    logic             start;
    logic [REP_W-1:0] reps;
  } scan_start_t;

  typedef logic [ROWS-1:0][WORD_W-1:0] row_words_t;

endpackage

@@ design/led_matrix_scroll_row_scanner_top.sv @@
// Channel   Direction  Signals                    Contents (low bit first)
// s_axis    in         tvalid tready tdata[71:0]  glyph_rows[63:0], column[66:64]
// m_axis    out        tvalid tready tdata[31:0]  row_word
//                      tuser[3:0] tlast           row_position[2:0], frame_end[3]; last
// cfg       in         cfg_we_i cfg_wdata_i[3:0]  refresh_repeats
//
// Each word is scanned min(refresh_repeats, 8) times over all row positions; the scan
// sequencer emits one row word per cycle from the lane buffers while m_axis accepts.
// A word is taken while the previous word's final row still waits at m_axis.
// Reset clears all row buffers and loads refresh_repeats with 5.
// A stall on m_axis holds the sequencer; s_axis_tready is low while scanning.
module led_matrix_scroll_row_scanner_top import lmsrs_pkg::*; #(
  parameter int unsigned ROW_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // glyph_rows[63:0], column[66:64]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // row_word[31:0]
  output logic [3:0]  m_axis_tuser,  // row_position[2:0], frame_end[3]
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i
);

  logic [REP_W-1:0]            reps_q;
  logic [REP_W-1:0]            reps_sat;
  logic                        busy;
  logic                        accept;
  logic [ROWS*GLYPH_WIDTH-1:0] glyph;
  logic [POS_W-1:0]            column;
  row_words_t                  rows;
  scan_start_t                 start;
  logic [POS_W-1:0]            row_position;
  logic                        frame_end;

  // Hold the refresh repeat register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reps_q <= REPEAT_RESET;
    end else if (cfg_we_i) begin
      reps_q <= cfg_wdata_i;
    end
  end

  assign reps_sat      = (reps_q > REPEAT_MAX) ? REPEAT_MAX : reps_q;
  assign s_axis_tready = !busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign glyph         = s_axis_tdata[ROWS*GLYPH_WIDTH-1:0];
  assign column        = s_axis_tdata[ROWS*GLYPH_WIDTH +: POS_W];
  assign start.start   = accept;
  assign start.reps    = reps_sat;

  // One lane per row buffer
  for (genvar r = 0; r < ROWS; r++) begin : g_lane
    lmsrs_lane #(
      .ROW_BITS (ROW_BITS)
    ) u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (accept),
      .row_byte_i (glyph[r*GLYPH_WIDTH +: GLYPH_WIDTH]),
      .column_i   (column),
      .row_word_o (rows[r])
    );
  end

  lmsrs_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .rows_i         (rows),
    .busy_o         (busy),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .row_word_o     (m_axis_tdata),
    .row_position_o (row_position),
    .frame_end_o    (frame_end),
    .last_o         (m_axis_tlast)
  );

  assign m_axis_tuser = {frame_end, row_position};

endmodule

@@ design/lmsrs_lane.sv @@
module lmsrs_lane import lmsrs_pkg::*; #(
  parameter int unsigned ROW_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   shift_i,
  input  logic [GLYPH_WIDTH-1:0] row_byte_i,
  input  logic [POS_W-1:0]       column_i,
  output logic [WORD_W-1:0]      row_word_o
);

  logic [ROW_BITS-1:0] row_q, row_d;
  logic                col_bit;

  // Column 0 is the leftmost, held in the byte's top bit
  assign col_bit = row_byte_i[~column_i];

  // Shift left and take the glyph column bit
  always_comb begin
    row_d = row_q;
    if (shift_i) begin
      row_d = {row_q[ROW_BITS-2:0], col_bit};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  // Present the low word of the buffer
  if (ROW_BITS >= WORD_W) begin : g_trunc
    assign row_word_o = row_q[WORD_W-1:0];
  end else begin : g_ext
    assign row_word_o = {{(WORD_W-ROW_BITS){1'b0}}, row_q};
  end

endmodule

@@ design/lmsrs_scan.sv @@
module lmsrs_scan import lmsrs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scan_start_t       start_i,
  input  row_words_t        rows_i,
  output logic              busy_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [WORD_W-1:0] row_word_o,
  output logic [POS_W-1:0]  row_position_o,
  output logic              frame_end_o,
  output logic              last_o
);

  logic              busy_q;
  logic [POS_W-1:0]  pos_q;
  logic [REP_W-1:0]  rep_left_q;
  logic              valid_q;
  logic [WORD_W-1:0] word_q;
  logic [POS_W-1:0]  opos_q;
  logic              frame_q;
  logic              last_q;
  logic              advance;
  logic [POS_W-1:0]  src;

  // While busy, produce a word whenever the output register is free or being drained
  assign advance = busy_q && (!valid_q || out_ready_i);
  // Position i shows buffer (i+1) mod ROWS
  assign src     = pos_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      pos_q      <= '0;
      rep_left_q <= '0;
      valid_q    <= 1'b0;
    end else begin
      // Drop the word once taken
      if (valid_q && out_ready_i && !advance) begin
        valid_q <= 1'b0;
      end
      if (start_i.start) begin
        busy_q     <= (start_i.reps != '0);
        pos_q      <= '0;
        rep_left_q <= start_i.reps;
      end else if (advance) begin
        valid_q <= 1'b1;
        pos_q   <= pos_q + 1'b1;
        if (pos_q == POS_LAST) begin
          rep_left_q <= rep_left_q - 1'b1;
          if (rep_left_q == 4'd1) begin
            busy_q <= 1'b0;
          end
        end
      end
    end
  end

  // Merge: pick the lane for this position into the output register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      word_q  <= rows_i[src];
      opos_q  <= pos_q;
      frame_q <= (pos_q == POS_LAST);
      last_q  <= (pos_q == POS_LAST) && (rep_left_q == 4'd1);
    end
  end

  assign busy_o         = busy_q;
  assign out_valid_o    = valid_q;
  assign row_word_o     = word_q;
  assign row_position_o = opos_q;
  assign frame_end_o    = frame_q;
  assign last_o         = last_q;

  a_busy_has_reps : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rep_left_q != '0))
    else $error("scan busy with no refresh left");

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i.start && start_i.reps != '0) |=> busy_q)
    else $error("scan did not start");

  a_last_on_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && last_q) |-> (frame_q && opos_q == POS_LAST))
    else $error("last word off the frame end");

  a_pos_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !advance && !start_i.start) |=> $stable(pos_q))
    else $error("scan position moved while stalled");

endmodule
